[hdl/rvenc_pkg.sv]
package rvenc_pkg;

    localparam int PAD_NOPS_DEFAULT    = 5;
    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam int NUM_OPS             = 43;

    localparam logic [31:0] HALT_WORD = 32'h0000000B;

    typedef enum logic [3:0] {
        K_R     = 4'd0,
        K_I     = 4'd1,
        K_SHIFT = 4'd2,
        K_S     = 4'd3,
        K_B     = 4'd4,
        K_J     = 4'd5,
        K_U     = 4'd6,
        K_FIXED = 4'd7,
        K_VMEM  = 4'd8,
        K_NONE  = 4'd9
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [6:0]  opcode;
        logic [2:0]  f3;
        logic [6:0]  f7;
    } op_desc_t;

    typedef struct packed {
        op_desc_t    desc;
        logic [4:0]  r1;
        logic [4:0]  r2;
        logic [4:0]  r3;
        logic [31:0] operand;
    } rvenc_entry_t;

    localparam op_desc_t OP_TABLE [NUM_OPS] = '{
        '{K_R, 7'h33, 3'd0, 7'h00}, '{K_R, 7'h33, 3'd0, 7'h20},
        '{K_R, 7'h33, 3'd2, 7'h00}, '{K_R, 7'h33, 3'd3, 7'h00},
        '{K_R, 7'h33, 3'd7, 7'h00}, '{K_R, 7'h33, 3'd6, 7'h00},
        '{K_R, 7'h33, 3'd4, 7'h00}, '{K_R, 7'h33, 3'd1, 7'h00},
        '{K_R, 7'h33, 3'd5, 7'h00}, '{K_R, 7'h33, 3'd5, 7'h20},
        '{K_I, 7'h13, 3'd0, 7'h00}, '{K_I, 7'h13, 3'd2, 7'h00},
        '{K_I, 7'h13, 3'd3, 7'h00}, '{K_I, 7'h13, 3'd7, 7'h00},
        '{K_I, 7'h13, 3'd6, 7'h00}, '{K_I, 7'h13, 3'd4, 7'h00},
        '{K_SHIFT, 7'h13, 3'd1, 7'h00}, '{K_SHIFT, 7'h13, 3'd5, 7'h00},
        '{K_SHIFT, 7'h13, 3'd5, 7'h20},
        '{K_I, 7'h03, 3'd0, 7'h00}, '{K_I, 7'h03, 3'd4, 7'h00},
        '{K_I, 7'h03, 3'd1, 7'h00}, '{K_I, 7'h03, 3'd5, 7'h00},
        '{K_I, 7'h03, 3'd2, 7'h00},
        '{K_S, 7'h23, 3'd0, 7'h00}, '{K_S, 7'h23, 3'd1, 7'h00},
        '{K_S, 7'h23, 3'd2, 7'h00},
        '{K_B, 7'h63, 3'd0, 7'h00}, '{K_B, 7'h63, 3'd5, 7'h00},
        '{K_B, 7'h63, 3'd7, 7'h00}, '{K_B, 7'h63, 3'd4, 7'h00},
        '{K_B, 7'h63, 3'd6, 7'h00}, '{K_B, 7'h63, 3'd1, 7'h00},
        '{K_J, 7'h6F, 3'd0, 7'h00},
        '{K_I, 7'h67, 3'd0, 7'h00},
        '{K_U, 7'h17, 3'd0, 7'h00},
        '{K_U, 7'h37, 3'd0, 7'h00},
        '{K_FIXED, 7'h0B, 3'd0, 7'h00},
        '{K_R, 7'h33, 3'd0, 7'h01},
        '{K_R, 7'h57, 3'd0, 7'h00}, '{K_R, 7'h57, 3'd4, 7'h00},
        '{K_VMEM, 7'h07, 3'd0, 7'h00}, '{K_VMEM, 7'h27, 3'd0, 7'h00}
    };

    function automatic op_desc_t op_decode(input logic [5:0] cmd);
        op_desc_t d;
        if (cmd < 6'(NUM_OPS))
        begin
            d = OP_TABLE[cmd];
        end
        else
        begin
            d = '{K_NONE, 7'h00, 3'd0, 7'h00};
        end
        return d;
    endfunction

endpackage

[hdl/rvenc_in_if.sv]
interface rvenc_in_if;
    logic               valid;
    logic               ready;
    logic [5:0]         cmd;
    logic [4:0]         first_reg;
    logic [4:0]         second_reg;
    logic [4:0]         third_reg;
    logic signed [31:0] imm_value;

    modport source (output valid, output cmd, output first_reg, output second_reg,
                    output third_reg, output imm_value, input ready);
    modport sink (input valid, input cmd, input first_reg, input second_reg,
                  input third_reg, input imm_value, output ready);
endinterface

[hdl/rvenc_out_if.sv]
interface rvenc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] machine_word;
    logic        unimplemented;
    logic        last;

    modport source (output valid, output machine_word, output unimplemented,
                    output last, input ready);
    modport sink (input valid, input machine_word, input unimplemented,
                  input last, output ready);
endinterface

[hdl/riscv_instruction_encoder_top.sv]
// RV32IM instruction encoder with a small vector extension.
// The instr channel takes one assembled instruction per transfer: a selector,
// three register numbers and an immediate. The code channel returns machine
// words. An implemented selector gives one transfer with last set; branch and
// JAL targets become offsets from four times the count of implemented items.
// An unimplemented selector gives PAD_NOPS + 2 transfers, all flagged
// unimplemented: a zero word, PAD_NOPS zero padding words and the halt word
// with last set, and it clears the instruction counter.
// An instr transfer is written to the queue and then to the output register.
// The front end accepts one item per cycle while the QUEUE_DEPTH entry queue
// has room; while the receiver is ready, the back end emits one word per cycle
// from its output register, so an unimplemented item takes PAD_NOPS + 2 words.
// When the receiver stalls, the output register holds its word and the queue
// fills; instr.ready drops only when the queue is full.
// Reset empties the queue and the output register and clears the counter.
module riscv_instruction_encoder_top #(
    parameter int PAD_NOPS    = rvenc_pkg::PAD_NOPS_DEFAULT,
    parameter int QUEUE_DEPTH = rvenc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    rvenc_in_if.sink    instr,
    rvenc_out_if.source code
);
    import rvenc_pkg::*;

    logic         push_valid;
    rvenc_entry_t push_entry;
    logic         queue_full;
    logic         head_valid;
    rvenc_entry_t head_entry;
    logic         pop;

    rvenc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .instr      (instr),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    rvenc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop)
    );

    rvenc_back #(
        .PAD_NOPS (PAD_NOPS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .code       (code)
    );

endmodule

[hdl/rvenc_front.sv]
module rvenc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    rvenc_in_if.sink              instr,
    input  logic                  queue_full,
    output logic                  push_valid,
    output rvenc_pkg::rvenc_entry_t push_entry
);
    import rvenc_pkg::*;

    logic [31:0] count_reg;
    logic [31:0] count_next;
    logic [31:0] offset;
    op_desc_t    desc;
    logic        fire;

    assign instr.ready = !queue_full;
    assign fire        = instr.valid && !queue_full;
    assign desc        = op_decode(instr.cmd);
    assign offset      = instr.imm_value - {count_reg[29:0], 2'b00};

    always_comb
    begin
        push_entry.desc = desc;
        push_entry.r1   = instr.first_reg;
        push_entry.r2   = instr.second_reg;
        push_entry.r3   = instr.third_reg;
        if (desc.kind == K_B || desc.kind == K_J)
        begin
            push_entry.operand = offset;
        end
        else
        begin
            push_entry.operand = instr.imm_value;
        end
    end

    assign push_valid = fire;

    always_comb
    begin
        count_next = count_reg;
        if (fire)
        begin
            if (desc.kind == K_NONE)
            begin
                count_next = '0;
            end
            else
            begin
                count_next = count_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && desc.kind == K_NONE) |=> (count_reg == 32'd0))
        else $error("Instruction counter not cleared after an unimplemented item.");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && desc.kind != K_NONE) |=> (count_reg == $past(count_reg) + 32'd1))
        else $error("Instruction counter did not advance by one.");

    a_offset_only_pc_rel: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && desc.kind != K_B && desc.kind != K_J)
            |-> (push_entry.operand == instr.imm_value))
        else $error("Immediate altered for a form that is not PC relative.");

endmodule

[hdl/rvenc_queue.sv]
module rvenc_queue #(
    parameter int DEPTH = rvenc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push_valid,
    input  rvenc_pkg::rvenc_entry_t push_entry,
    output logic                    full,
    output logic                    head_valid,
    output rvenc_pkg::rvenc_entry_t head_entry,
    input  logic                    pop
);
    import rvenc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rvenc_entry_t       entries [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = entries[rd_ptr_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("Queue holds more entries than its depth.");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("Queue popped while empty.");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && !full && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("Queue occupancy did not follow a push.");

endmodule

[hdl/rvenc_back.sv]
module rvenc_back #(
    parameter int PAD_NOPS = rvenc_pkg::PAD_NOPS_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    head_valid,
    input  rvenc_pkg::rvenc_entry_t head_entry,
    output logic                    pop,
    rvenc_out_if.source             code
);
    import rvenc_pkg::*;

    localparam int LAST_IDX = PAD_NOPS + 1;
    localparam int SEQ_W    = $clog2(PAD_NOPS + 2);

    logic [SEQ_W-1:0] seq_reg;
    logic [SEQ_W-1:0] seq_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [31:0]      word_reg;
    logic [31:0]      word_next;
    logic             unimpl_reg;
    logic             unimpl_next;
    logic             last_reg;
    logic             last_next;
    logic             slot_free;
    logic             load;
    logic             seq_end;

    function automatic logic [31:0] encode(input rvenc_entry_t e);
        logic [31:0] w;
        logic [31:0] v;
        v = e.operand;
        case (e.desc.kind)
            K_R:     w = {e.desc.f7, e.r3, e.r2, e.desc.f3, e.r1, e.desc.opcode};
            K_I:     w = {v[11:0], e.r2, e.desc.f3, e.r1, e.desc.opcode};
            K_SHIFT: w = {e.desc.f7, v[4:0], e.r2, e.desc.f3, e.r1, e.desc.opcode};
            K_S:     w = {v[11:5], e.r1, e.r2, e.desc.f3, v[4:0], e.desc.opcode};
            K_B:     w = {v[12], v[10:5], e.r2, e.r1, e.desc.f3, v[4:1], v[11],
                          e.desc.opcode};
            K_J:     w = {v[20], v[10:1], v[11], v[19:12], e.r1, e.desc.opcode};
            K_U:     w = {v[19:0], e.r1, e.desc.opcode};
            K_VMEM:  w = {12'd0, e.r2, e.desc.f3, e.r1, e.desc.opcode};
            default: w = HALT_WORD;
        endcase
        return w;
    endfunction

    assign slot_free = !out_valid_reg || code.ready;
    assign load      = head_valid && slot_free;
    assign seq_end   = (seq_reg == SEQ_W'(LAST_IDX));

    always_comb
    begin
        seq_next       = seq_reg;
        out_valid_next = out_valid_reg;
        word_next      = word_reg;
        unimpl_next    = unimpl_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        if (slot_free)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
            if (head_entry.desc.kind == K_NONE)
            begin
                word_next   = seq_end ? HALT_WORD : 32'd0;
                unimpl_next = 1'b1;
                last_next   = seq_end;
                pop         = seq_end;
                seq_next    = seq_end ? '0 : seq_reg + 1'b1;
            end
            else
            begin
                word_next   = encode(head_entry);
                unimpl_next = 1'b0;
                last_next   = 1'b1;
                pop         = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg   <= word_next;
        unimpl_reg <= unimpl_next;
        last_reg   <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign code.valid         = out_valid_reg;
    assign code.machine_word  = word_reg;
    assign code.unimplemented = unimpl_reg;
    assign code.last          = last_reg;

    a_seq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg <= SEQ_W'(LAST_IDX))
        else $error("Padding sequence counter ran past the halt word.");

    a_halt_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && unimpl_reg && last_reg) |-> (word_reg == HALT_WORD))
        else $error("Final transfer of an unimplemented item is not the halt word.");

    a_impl_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !unimpl_reg) |-> (last_reg && seq_reg == '0))
        else $error("Implemented item did not end in a single transfer.");

endmodule
